### design/srl_pkg.sv
// Shared constants, register codes and controller/datapath interface types.
package srl_pkg;

  // Default sizes of the admission log.
  localparam int LOG_DEPTH_DEF = 64;
  localparam int TIME_BITS_DEF = 32;

  // Stream payload widths.
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;
  localparam int OCC_W       = 7;

  // Configuration register widths.
  localparam int MAX_ADM_W  = 7;
  localparam int WINDOW_W   = 31;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ADM = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'd1;

  // Configuration reset values.
  localparam logic [MAX_ADM_W-1:0] MAX_ADM_RST = 7'd20;
  localparam logic [WINDOW_W-1:0]  WINDOW_RST  = 31'd1000000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // latch the request time
    logic pop;       // drop the oldest log entry
    logic append;    // log the request time and admit it
    logic clr_ok;    // mark the request as refused
    logic load_out;  // move the result into the output register
  } srl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic limit_zero;    // limit register is zero
    logic log_empty;     // no entries logged
    logic head_expired;  // oldest entry is at least one window old
    logic has_room;      // log holds fewer entries than the limit
    logic out_free;      // output register can take a result
  } srl_status_t;

endpackage

### design/srl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module srl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/srl_ctrl.sv
// Controller state machine that sequences expiry, admission and result hand-off.
module srl_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  srl_pkg::srl_status_t status,
  output srl_pkg::srl_cmd_t    cmd
);

  import srl_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WAIT  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (status.limit_zero) begin
            cmd.clr_ok = 1'b1;
            state_nxt  = S_OUT;
          end else begin
            state_nxt  = S_CHECK;
          end
        end
      end
      S_WAIT: begin
        // The RAM read of the new head lands during this cycle.
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!status.log_empty && status.head_expired) begin
          cmd.pop   = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          if (status.has_room) begin
            cmd.append = 1'b1;
          end else begin
            cmd.clr_ok = 1'b1;
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/srl_dp.sv
// Datapath: configuration registers, time log with head and count, output register.
module srl_dp #(
  parameter int LOG_DEPTH = srl_pkg::LOG_DEPTH_DEF,
  parameter int TIME_BITS = srl_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [srl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [srl_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [srl_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  srl_pkg::srl_cmd_t               cmd,
  output srl_pkg::srl_status_t            status
);

  import srl_pkg::*;

  localparam int IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W = $clog2(LOG_DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam int LIM_W = (CNT_W > MAX_ADM_W) ? CNT_W : MAX_ADM_W;
  localparam int CMP_W = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;

  logic [MAX_ADM_W-1:0] max_adm_r;
  logic [WINDOW_W-1:0]  window_r;
  logic [TIME_BITS-1:0] now_r;
  logic [IDX_W-1:0]     head_r;
  logic [IDX_W-1:0]     head_nxt;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 ok_r;
  logic                 out_valid_r;
  logic                 out_admitted_r;
  logic [OCC_W-1:0]     out_occ_r;

  logic [TIME_BITS-1:0] head_time;
  logic [TIME_BITS-1:0] age;
  logic [SUM_W-1:0]     tail_sum;
  logic [IDX_W-1:0]     tail_idx;
  logic [LIM_W-1:0]     limit_req;
  logic [LIM_W-1:0]     limit_cap;
  logic [LIM_W-1:0]     limit;

  // Configuration registers; writes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_adm_r <= MAX_ADM_RST;
      window_r  <= WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_ADM: max_adm_r <= cfg_wdata[MAX_ADM_W-1:0];
        CFG_WINDOW:  window_r  <= cfg_wdata[WINDOW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request time, taken modulo the log's time width.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_r <= TIME_BITS'(in_tdata);
    end
  end

  // Slot after the newest entry, wrapped into the log.
  assign tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail_idx = (tail_sum >= SUM_W'(LOG_DEPTH)) ? IDX_W'(tail_sum - SUM_W'(LOG_DEPTH))
                                                     : IDX_W'(tail_sum);

  // The log itself; the read port always follows the head.
  srl_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (LOG_DEPTH)
  ) u_log (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (tail_idx),
    .wdata (now_r),
    .raddr (head_r),
    .rdata (head_time)
  );

  // Head and count updates for pops and appends.
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.pop) begin
      head_nxt  = (head_r == IDX_W'(LOG_DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
      count_nxt = count_r - CNT_W'(1);
    end else if (cmd.append) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Admission flag for the request in progress.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      ok_r <= 1'b1;
    end else if (cmd.clr_ok) begin
      ok_r <= 1'b0;
    end
  end

  // Age of the oldest entry; a negative age never expires.
  assign age = now_r - head_time;

  // Limit saturates at the log depth.
  assign limit_req = LIM_W'(max_adm_r);
  assign limit_cap = LIM_W'(LOG_DEPTH);
  assign limit     = (limit_req > limit_cap) ? limit_cap : limit_req;

  // Output register parts the result from the next request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_admitted_r <= ok_r;
      out_occ_r      <= OCC_W'(count_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_occ_r, out_admitted_r};

  // Status for the controller.
  always_comb begin
    status.limit_zero   = (max_adm_r == '0);
    status.log_empty    = (count_r == '0);
    status.head_expired = !age[TIME_BITS-1] && (CMP_W'(age) >= CMP_W'(window_r));
    status.has_room     = (LIM_W'(count_r) < limit);
    status.out_free     = !out_valid_r || out_tready;
  end

endmodule

### design/sliding_window_rate_limiter.sv
// Sliding-window log rate limiter: top level joining controller and datapath.
//
// Each request on the input stream carries its arrival time; unless the limit
// is zero, the block drops every logged admission at least one window old, then
// admits and logs it if fewer than max_admissions entries (capped at the
// log depth) remain, and returns one result (admitted flag and log occupancy)
// per request. After its transfer a request passes the check and hand-off
// states, or only hand-off at a zero limit, before the next input transfer;
// each expired entry adds a pop and a wait state, as each pop waits on the
// registered read of the log RAM at the new head. A result not yet taken on
// the output holds the controller in its hand-off state. The log RAM needs no
// clearing after reset: only entries written since reset are ever read.
module sliding_window_rate_limiter #(
  parameter int LOG_DEPTH = srl_pkg::LOG_DEPTH_DEF,
  parameter int TIME_BITS = srl_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [srl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Request stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [srl_pkg::IN_TDATA_W-1:0]  in_tdata,   // [31:0] arrival_time
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [srl_pkg::OUT_TDATA_W-1:0] out_tdata   // [0] admitted, [7:1] log_occupancy
);

  import srl_pkg::*;

  srl_cmd_t    cmd;
  srl_status_t status;

  // Sequencer.
  srl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Log, configuration and result registers.
  srl_dp #(
    .LOG_DEPTH (LOG_DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

### design/srl_checker.sv
// Port-level assertions for the rate limiter and the bind that attaches them.
module srl_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [srl_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import srl_pkg::*;

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // One request at a time: after a transfer the input is busy.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transfer");

  // No result can be finished in the cycle after a request transfer.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared too early");

  // Reset leaves the block ready with no result pending.
  a_reset_state: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> in_tready && !out_tvalid)
    else $error("block not idle after reset");

endmodule

bind sliding_window_rate_limiter srl_checker u_srl_checker (.*);

### tb/sliding_window_rate_limiter_test.sv
// Self-checking testbench for the sliding-window rate limiter.
module sliding_window_rate_limiter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srl_pkg::*;

  // One result of the limiter: admit flag and log fill after the request.
  typedef struct packed {
    logic             admitted;
    logic [OCC_W-1:0] occupancy;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_MAX_ADM;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [31:0] arrival_time

  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [0] admitted, [7:1] log_occupancy

  // Shadow copy of the admission log and the registers.
  logic [31:0]          shadow_times [LOG_DEPTH_DEF];
  logic [5:0]           shadow_head = '0;
  logic [OCC_W-1:0]     shadow_count = '0;
  logic [MAX_ADM_W-1:0] shadow_limit = MAX_ADM_RST;
  logic [WINDOW_W-1:0]  shadow_window = WINDOW_RST;

  logic [31:0] request_times [$];
  verdict_t    expected_verdicts [$];
  verdict_t    oldest_verdict;
  int          sent_count = 0;
  int          taken_count = 0;
  int          errors = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  bit          steady = 1'b0;
  logic [31:0] clock_now;

  sliding_window_rate_limiter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // Expire stale entries, then admit and log the request if there is room.
  task automatic admit_request(input logic [31:0] now);
    logic [OCC_W-1:0] cap;
    logic [31:0]      age;
    logic [5:0]       slot;
    bit               draining;
    verdict_t         verdict;
    cap = (shadow_limit > OCC_W'(LOG_DEPTH_DEF)) ? OCC_W'(LOG_DEPTH_DEF) : shadow_limit;
    verdict.admitted = 1'b0;
    if (cap != 0) begin
      draining = 1'b1;
      while (draining && shadow_count != 0) begin
        age = now - shadow_times[shadow_head];
        // A negative age means the clock stepped back: keep the entry.
        if (age[31] || age < {1'b0, shadow_window}) begin
          draining = 1'b0;
        end else begin
          shadow_head = shadow_head + 6'd1;
          shadow_count = shadow_count - OCC_W'(1);
        end
      end
      if (shadow_count < cap) begin
        slot = shadow_head + shadow_count[5:0];
        shadow_times[slot] = now;
        shadow_count = shadow_count + OCC_W'(1);
        verdict.admitted = 1'b1;
      end
    end
    verdict.occupancy = shadow_count;
    expected_verdicts = {expected_verdicts, verdict};
  endtask

  // Request driver: takes arrival times from the pending queue.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        admit_request(in_tdata);
        taken_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (request_times.size() != 0) begin
          in_tdata <= request_times[0];
          request_times.delete(0);
          in_tvalid <= 1'b1;
          if (!steady && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 10);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each transfer with the oldest expected verdict.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $time, out_tdata);
          errors++;
        end else begin
          oldest_verdict = expected_verdicts[0];
          expected_verdicts.delete(0);
          if (out_tdata[0] !== oldest_verdict.admitted) begin
            $display("%0t: admitted mismatch, expected %0d, actual %0d",
                     $time, oldest_verdict.admitted, out_tdata[0]);
            errors++;
          end
          if (out_tdata[7:1] !== oldest_verdict.occupancy) begin
            $display("%0t: log_occupancy mismatch, expected %0d, actual %0d",
                     $time, oldest_verdict.occupancy, out_tdata[7:1]);
            errors++;
          end
        end
      end
      if (out_gap != 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!steady && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 10);
      end
    end
  end

  task automatic queue_request(input logic [31:0] t);
    request_times = {request_times, t};
    sent_count++;
  endtask

  // Wait until every request has been taken and answered.
  task automatic wait_idle();
    while (taken_count != sent_count || expected_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_ADM) shadow_limit = data[MAX_ADM_W-1:0];
    else shadow_window = data[WINDOW_W-1:0];
  endtask

  task automatic set_limits(input logic [MAX_ADM_W-1:0] limit,
                            input logic [WINDOW_W-1:0] window);
    wait_idle();
    write_reg(CFG_MAX_ADM, CFG_DATA_W'(limit));
    write_reg(CFG_WINDOW, CFG_DATA_W'(window));
  endtask

  // Mostly forward-moving request times paced to the window, with some
  // backward steps, random times, boundary hits and mass-expiry jumps.
  task automatic queue_traffic(input int count);
    longint span;
    int     cap;
    int     pick;
    cap = (shadow_limit == 0) ? 1 : ((shadow_limit > 64) ? 64 : int'(shadow_limit));
    clock_now = $urandom();
    for (int i = 0; i < count; i++) begin
      span = (longint'(shadow_window) * $urandom_range(1, 4)) / (2 * cap);
      if (span < 2) span = 2;
      if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
      pick = $urandom_range(0, 99);
      if (pick < 80) clock_now += $urandom_range(0, 32'(span));
      else if (pick < 87) clock_now -= $urandom_range(0, 32'(span));
      else if (pick < 92) clock_now = $urandom();
      else if (pick < 96) clock_now += {1'b0, shadow_window};
      else clock_now += {1'b0, shadow_window} + ($urandom() & 32'h0FFF_FFFF);
      queue_request(clock_now);
    end
  endtask

  // Stimulus and end of run.
  initial begin
    logic [MAX_ADM_W-1:0] phase_limit [7];
    logic [WINDOW_W-1:0]  phase_window [7];
    logic [MAX_ADM_W-1:0] limit;
    logic [WINDOW_W-1:0]  window;
    phase_limit = '{7'd64, 7'd127, 7'd65, 7'd1, 7'd0, 7'd5, 7'd20};
    phase_window = '{31'd100000, 31'd5000, 31'h7FFF_FFFF, 31'd1, 31'd12345, 31'd0,
                     31'd1000000};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: field extremes, backward times, then expiry of all.
    queue_request(32'd0);
    queue_request(32'd0);
    queue_request(32'd1);
    queue_request(32'hFFFF_FFFF);
    queue_request(32'h8000_0000);
    queue_request(32'h7FFF_FFFF);
    queue_request(32'd999_999);
    queue_request(32'd1_000_000);
    queue_request(32'd5_000_000);

    // Zero limit refuses and leaves the log alone.
    set_limits(7'd0, 31'd1000000);
    queue_request(32'd10);
    queue_request(32'hFFFF_FFFF);

    // Zero window: anything not in the future expires.
    set_limits(7'd3, 31'd0);
    queue_request(32'd7);
    queue_request(32'd7);
    queue_request(32'd7);
    queue_request(32'd6);
    queue_request(32'd6);
    queue_request(32'd8);

    // Largest window, ages right at the sign boundary.
    set_limits(7'd2, 31'h7FFF_FFFF);
    queue_request(32'd0);
    queue_request(32'h7FFF_FFFE);
    queue_request(32'h7FFF_FFFF);
    queue_request(32'hFFFF_FFFF);
    queue_request(32'd0);

    // Random phases over a range of settings.
    for (int p = 0; p < 14; p++) begin
      if (p < 7) begin
        limit = phase_limit[p];
        window = phase_window[p];
      end else begin
        limit = MAX_ADM_W'($urandom_range(0, 127));
        case ($urandom_range(0, 3))
          0: window = WINDOW_W'($urandom_range(0, 64));
          1: window = WINDOW_W'($urandom_range(100, 100000));
          2: window = WINDOW_W'($urandom() & 32'h7FFF_FFFF);
          default: window = 31'h7FFF_FFFF;
        endcase
      end
      set_limits(limit, window);
      queue_traffic((limit == 0) ? 20 : 85);
    end

    // Last part at full rate on both sides.
    set_limits(7'd64, 31'd20000);
    steady = 1'b1;
    queue_traffic(80);

    wait_idle();
    repeat (200) @(negedge clk);
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
